>>> src/dchs_pkg.sv
package dchs_pkg;

  localparam int unsigned TotalW = 55;
  localparam int unsigned ClampW = 28;
  localparam int unsigned CthW   = 24;
  localparam int unsigned CylW   = 16;
  localparam int unsigned HeadW  = 5;
  localparam int unsigned SptW   = 8;
  localparam int unsigned DivW   = HeadW + CylW - 1;
  localparam int unsigned NumCells = CylW;
  localparam int unsigned RecipShift = 36;

  localparam logic [ClampW-1:0] MaxSectors  = ClampW'(65535 * 16 * 255);
  localparam logic [ClampW-1:0] LargeSectors = ClampW'(65535 * 16 * 63);

  localparam logic [SptW-1:0] Spt17  = 8'd17;
  localparam logic [SptW-1:0] Spt31  = 8'd31;
  localparam logic [SptW-1:0] Spt63  = 8'd63;
  localparam logic [SptW-1:0] Spt255 = 8'd255;

  localparam logic [HeadW-1:0] HeadsMin = 5'd4;
  localparam logic [HeadW-1:0] HeadsMax = 5'd16;

  localparam logic [31:0] Recip17  = 32'((64'd1 << RecipShift) / 64'd17);
  localparam logic [31:0] Recip31  = 32'((64'd1 << RecipShift) / 64'd31);
  localparam logic [31:0] Recip63  = 32'((64'd1 << RecipShift) / 64'd63);
  localparam logic [31:0] Recip255 = 32'((64'd1 << RecipShift) / 64'd255);

  typedef struct packed {
    logic             valid;
    logic [CthW-1:0]  rem;
    logic [DivW-1:0]  dsh;
    logic [CylW-1:0]  quo;
    logic [HeadW-1:0] heads;
    logic [SptW-1:0]  spt;
  } cell_t;

  function automatic logic [CthW-1:0] approx_quo(input logic [ClampW-1:0] t,
                                                 input logic [31:0] recip);
    logic [ClampW+31:0] prod;
    prod = {32'd0, t} * {{ClampW{1'b0}}, recip};
    return prod[RecipShift +: CthW];
  endfunction

  function automatic logic [CthW-1:0] fix_quo(input logic [ClampW-1:0] t,
                                              input logic [CthW-1:0] q0,
                                              input logic [SptW-1:0] d);
    logic [ClampW+SptW-1:0] back;
    logic [ClampW-1:0]      r;
    back = {{(ClampW-CthW){1'b0}}, q0, {SptW{1'b0}}} >> SptW;
    back = back * {{ClampW{1'b0}}, d};
    r    = t - back[ClampW-1:0];
    return (r >= {{(ClampW-SptW){1'b0}}, d}) ? q0 + CthW'(1) : q0;
  endfunction

endpackage

>>> src/dchs_if.sv
interface dchs_in_if;
  import dchs_pkg::*;
  logic              valid;
  logic              ready;
  logic [TotalW-1:0] total_sectors;
  modport source (output valid, output total_sectors, input ready);
  modport sink (input valid, input total_sectors, output ready);
endinterface

interface dchs_out_if;
  import dchs_pkg::*;
  logic             valid;
  logic             ready;
  logic [CylW-1:0]  cylinders;
  logic [HeadW-1:0] heads;
  logic [SptW-1:0]  sectors_per_track;
  modport source (output valid, output cylinders, output heads, output sectors_per_track,
                  input ready);
  modport sink (input valid, input cylinders, input heads, input sectors_per_track,
                output ready);
endinterface

>>> src/dchs_front.sv
module dchs_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic                            valid_i,
  input  logic [dchs_pkg::TotalW-1:0]     total_i,
  output dchs_pkg::cell_t                 cell_o
);
  import dchs_pkg::*;

  logic              v0_q, v1_q, v2_q;
  logic [ClampW-1:0] t0_q, t1_q, t2_q;
  logic [CthW-1:0]   a17_q, a31_q, a63_q, a255_q;
  logic [CthW-1:0]   q17_q, q31_q, q63_q, q255_q;
  logic [ClampW-1:0] t0_d;
  logic [CthW+HeadW-1:0] hd_wide;
  logic [HeadW-1:0]  hd;
  logic              big17, big31;
  logic [CthW-1:0]   cth;
  logic [HeadW-1:0]  heads;
  logic [SptW-1:0]   spt;
  cell_t             cell_d, cell_q;

  assign t0_d = (total_i > {{(TotalW-ClampW){1'b0}}, MaxSectors}) ? MaxSectors
                                                                   : total_i[ClampW-1:0];

  always_comb begin
    hd_wide = ({{HeadW{1'b0}}, q17_q} + (CthW+HeadW)'(1023)) >> 10;
    if (hd_wide < (CthW+HeadW)'(HeadsMin)) begin
      hd = HeadsMin;
    end else if (hd_wide > (CthW+HeadW)'(HeadsMax)) begin
      hd = HeadsMax;
    end else begin
      hd = hd_wide[HeadW-1:0];
    end
    big17 = (hd_wide > (CthW+HeadW)'(HeadsMax)) ||
            ({{HeadW{1'b0}}, q17_q} >= ((CthW+HeadW)'(hd) << 10));
    big31 = q31_q >= (CthW'(HeadsMax) << 10);
    if (t2_q >= LargeSectors) begin
      cth = q255_q; heads = HeadsMax; spt = Spt255;
    end else if (!big17) begin
      cth = q17_q; heads = hd; spt = Spt17;
    end else if (!big31) begin
      cth = q31_q; heads = HeadsMax; spt = Spt31;
    end else begin
      cth = q63_q; heads = HeadsMax; spt = Spt63;
    end
    cell_d.valid = v2_q;
    cell_d.rem   = cth;
    cell_d.dsh   = DivW'(heads) << (CylW - 1);
    cell_d.quo   = '0;
    cell_d.heads = heads;
    cell_d.spt   = spt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      cell_q <= '0;
    end else if (adv_i) begin
      v0_q   <= valid_i;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      cell_q <= cell_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      t0_q   <= t0_d;
      t1_q   <= t0_q;
      a17_q  <= approx_quo(t0_q, Recip17);
      a31_q  <= approx_quo(t0_q, Recip31);
      a63_q  <= approx_quo(t0_q, Recip63);
      a255_q <= approx_quo(t0_q, Recip255);
      t2_q   <= t1_q;
      q17_q  <= fix_quo(t1_q, a17_q, Spt17);
      q31_q  <= fix_quo(t1_q, a31_q, Spt31);
      q63_q  <= fix_quo(t1_q, a63_q, Spt63);
      q255_q <= fix_quo(t1_q, a255_q, Spt255);
    end
  end

  assign cell_o = cell_q;

endmodule

>>> src/dchs_cell.sv
module dchs_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  dchs_pkg::cell_t cell_i,
  output dchs_pkg::cell_t cell_o
);
  import dchs_pkg::*;

  cell_t cell_d, cell_q;
  logic  fits;

  always_comb begin
    fits         = cell_i.rem >= CthW'(cell_i.dsh);
    cell_d       = cell_i;
    cell_d.rem   = fits ? cell_i.rem - CthW'(cell_i.dsh) : cell_i.rem;
    cell_d.dsh   = cell_i.dsh >> 1;
    cell_d.quo   = {cell_i.quo[CylW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (adv_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

>>> src/disk_chs_geometry.sv
// Disk CHS geometry: each transaction on in_i carries a total sector count and gives one
// transaction on out_o with the cylinder, head and sectors-per-track triple of the
// virtual disk footer rule (counts above 65535*16*255 clamp to it). One count is taken
// every cycle unless the output stalls. The pipeline is a clamp stage, two stages of
// reciprocal multiply and correction for the four sector counts, a select stage, and a
// row of 16 divider cells that each settle one cylinder bit. A stalled output holds the
// whole pipeline.
module disk_chs_geometry (
  input  logic       clk_i,
  input  logic       rst_ni,
  dchs_in_if.sink    in_i,
  dchs_out_if.source out_o
);
  import dchs_pkg::*;

  logic  adv;
  cell_t chain [NumCells+1];

  assign adv      = !chain[NumCells].valid || out_o.ready;
  assign in_i.ready = adv;

  dchs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_i.valid),
    .total_i (in_i.total_sectors),
    .cell_o  (chain[0])
  );

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    dchs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  assign out_o.valid             = chain[NumCells].valid;
  assign out_o.cylinders         = chain[NumCells].quo;
  assign out_o.heads             = chain[NumCells].heads;
  assign out_o.sectors_per_track = chain[NumCells].spt;

`ifndef SYNTHESIS
  a_heads_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.heads >= HeadsMin && out_o.heads <= HeadsMax))
    else $error("heads out of range");
  a_spt_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.sectors_per_track == Spt17 || out_o.sectors_per_track == Spt31 ||
                     out_o.sectors_per_track == Spt63 || out_o.sectors_per_track == Spt255))
    else $error("bad sectors per track");
  a_wide_heads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.sectors_per_track != Spt17) |-> out_o.heads == HeadsMax)
    else $error("wide track without 16 heads");
  a_small_cyl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.sectors_per_track == Spt17) |-> out_o.cylinders < CylW'(1024))
    else $error("cylinders too large for 17 sectors");
`endif

endmodule
